// ===== design/pccf_pkg.sv =====
package pccf_pkg;

   typedef logic [1:0] command_type;

   localparam command_type CMD_BEGIN = 2'd0;
   localparam command_type CMD_DATA  = 2'd1;
   localparam command_type CMD_END   = 2'd2;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam int RUN_BYTES = 8;
   localparam int RUN_CNT_W = 4;

   typedef struct packed {
      command_type command;
      logic [7:0]  data_byte;
      logic [30:0] chunk_length;
      logic [31:0] chunk_type;
      logic [31:0] pre_crc;
   } item_type;

   function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/pccf_if.sv =====
interface pccf_req_if;
   logic                 valid;
   logic                 ready;
   pccf_pkg::command_type command;
   logic [7:0]           data_byte;
   logic [30:0]          chunk_length;
   logic [31:0]          chunk_type;

   modport source (output valid, command, data_byte, chunk_length, chunk_type,
                   input ready);
   modport sink   (input valid, command, data_byte, chunk_length, chunk_type,
                   output ready);
endinterface

interface pccf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, out_byte, run_last, input ready);
   modport sink   (input valid, out_byte, run_last, output ready);
endinterface

// ===== design/pccf_crc.sv =====
module pccf_crc (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  pccf_pkg::item_type item,
   output logic [31:0]        crc_ff
);
   import pccf_pkg::*;

   logic [31:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (step) begin
         case (item.command)
            CMD_BEGIN: crc_in = fold_byte(fold_byte(item.pre_crc, item.chunk_type[15:8]),
                                          item.chunk_type[7:0]);
            CMD_DATA:  crc_in = fold_byte(crc_ff, item.data_byte);
            default:   crc_in = crc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ONES;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

// ===== design/pccf_ser.sv =====
module pccf_ser (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  pccf_pkg::item_type item,
   input  logic [31:0]        crc,
   input  logic               out_ready,
   output logic               free,
   output logic               out_valid,
   output logic [7:0]         out_byte,
   output logic               run_last
);
   import pccf_pkg::*;

   logic [RUN_BYTES*8-1:0] shift_ff, shift_in;
   logic [RUN_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign free      = (count_ff == '0) || (count_ff == RUN_CNT_W'(1) && out_ready);
   assign out_byte  = shift_ff[RUN_BYTES*8-1 -: 8];
   assign run_last  = (count_ff == RUN_CNT_W'(1));

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (pop) begin
         shift_in = {shift_ff[RUN_BYTES*8-9:0], 8'd0};
         count_in = count_ff - RUN_CNT_W'(1);
      end
      if (load) begin
         case (item.command)
            CMD_BEGIN: begin
               shift_in = {1'b0, item.chunk_length, item.chunk_type};
               count_in = RUN_CNT_W'(8);
            end
            CMD_DATA: begin
               shift_in = {item.data_byte, 56'd0};
               count_in = RUN_CNT_W'(1);
            end
            CMD_END: begin
               shift_in = {~crc, 32'd0};
               count_in = RUN_CNT_W'(4);
            end
            default: begin
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/png_chunk_crc_framer_core.sv =====
// PNG chunk framer. Each request beat is a command: begin sends the 31-bit
// length and the four type characters as eight big-endian bytes and restarts
// the CRC-32 over the type; data passes one byte through and folds it into the
// CRC; end sends the inverted CRC as four big-endian bytes; code 3 is dropped.
// Every response beat carries one byte, run_last marking the final byte of a
// command. Requests pass an input register into a byte serialiser, so data
// commands stream at one beat per cycle while rsp_chan is ready, passing the
// input register and then the shift register; a begin holds the request
// side for eight output beats and an end for four: the single-byte output
// port sets the rate. The given length is not checked against the bytes sent.
module png_chunk_crc_framer_core (
   input logic          clock,
   input logic          reset,
   pccf_req_if.sink     req_chan,
   pccf_rsp_if.source   rsp_chan
);
   import pccf_pkg::*;

   logic        in_valid_ff, in_valid_in;
   item_type    item_ff, item_in;
   logic        accept, move, ser_free;
   logic [31:0] crc;

   assign move           = in_valid_ff && ser_free;
   assign req_chan.ready = !in_valid_ff || ser_free;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (move) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in          = 1'b1;
         item_in.command      = req_chan.command;
         item_in.data_byte    = req_chan.data_byte;
         item_in.chunk_length = req_chan.chunk_length;
         item_in.chunk_type   = req_chan.chunk_type;
         item_in.pre_crc      = fold_byte(fold_byte(CRC_ONES, req_chan.chunk_type[31:24]),
                                          req_chan.chunk_type[23:16]);
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   pccf_crc u_crc (
      .clock  (clock),
      .reset  (reset),
      .step   (move),
      .item   (item_ff),
      .crc_ff (crc)
   );

   pccf_ser u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .item      (item_ff),
      .crc       (crc),
      .out_ready (rsp_chan.ready),
      .free      (ser_free),
      .out_valid (rsp_chan.valid),
      .out_byte  (rsp_chan.out_byte),
      .run_last  (rsp_chan.run_last)
   );

endmodule

// ===== design/pccf_checker.sv =====
module pccf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_run_last))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

   // a run of bytes never breaks before its last beat
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a byte run");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind png_chunk_crc_framer_core pccf_checker u_pccf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_run_last (rsp_chan.run_last)
);
